// ===== design/tgu_pkg.sv =====
package tgu_pkg;

	// Sample and arithmetic widths.
	localparam int SAMPLE_W = 24;
	// Extrapolated corners reach base plus six differences, so four guard bits.
	localparam int VAL_W    = SAMPLE_W + 4;
	localparam int DIFF_W   = VAL_W + 1;
	localparam int WEIGHT_W = 16;

	// Sample store geometry.
	localparam int ADDR_W      = 12;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	// Configuration and coordinate widths.
	localparam int FACTOR_W   = 4;
	localparam int SIZE_W     = 5;
	localparam int IDX_W      = 4;
	localparam int FINE_W     = 7;
	localparam int PLANE_W    = 2 * SIZE_W - 1;
	localparam int MAX_FACTOR = 8;
	localparam int MAX_AXIS   = 16;

	// Reciprocal multiply: one product gives quotient and Q0.16 weight.
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = RECIP_W + FINE_W;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_FACTOR = 3'd0;
	localparam logic [2:0] REG_SIZE_X = 3'd1;
	localparam logic [2:0] REG_SIZE_Y = 3'd2;
	localparam logic [2:0] REG_SIZE_Z = 3'd3;
	localparam logic [2:0] REG_WRAP   = 3'd4;

	// Request commands.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [WEIGHT_W-1:0]     weight_t;

	typedef struct packed {
		logic    start;
		val_t    a;
		val_t    b;
		weight_t w;
	} lerp_req_t;

	typedef struct packed {
		logic done;
		val_t result;
	} lerp_rsp_t;

	function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] v);
		logic [FACTOR_W-1:0] r;
		if (v == '0) begin
			r = FACTOR_W'(1);
		end else if (v > FACTOR_W'(MAX_FACTOR)) begin
			r = FACTOR_W'(MAX_FACTOR);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > SIZE_W'(MAX_AXIS)) begin
			r = SIZE_W'(MAX_AXIS);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Ceiling of 2^28 over the factor; exact quotients for all operands used here.
	function automatic logic [RECIP_W-1:0] recip(input logic [FACTOR_W-1:0] f);
		logic [RECIP_W-1:0] r;
		unique case (f)
			4'd2:    r = 29'd134217728;
			4'd3:    r = 29'd89478486;
			4'd4:    r = 29'd67108864;
			4'd5:    r = 29'd53687092;
			4'd6:    r = 29'd44739243;
			4'd7:    r = 29'd38347923;
			4'd8:    r = 29'd33554432;
			default: r = 29'd268435456;
		endcase
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] saturate(input val_t v);
		logic signed [SAMPLE_W-1:0] r;
		if (v > val_t'({1'b0, {(SAMPLE_W-1){1'b1}}})) begin
			r = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else if (v < -val_t'({1'b1, {(SAMPLE_W-1){1'b0}}})) begin
			r = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			r = v[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== design/tgu_store.sv =====
module tgu_store (
	input  logic                                clk,
	input  logic                                we,
	input  logic [tgu_pkg::ADDR_W-1:0]          waddr,
	input  logic [tgu_pkg::SAMPLE_W-1:0]        wdata,
	input  logic [tgu_pkg::ADDR_W-1:0]          raddr,
	output logic [tgu_pkg::SAMPLE_W-1:0]        rdata
);

	logic [tgu_pkg::SAMPLE_W-1:0] mem_q [tgu_pkg::STORE_DEPTH];
	logic [tgu_pkg::SAMPLE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/tgu_lerp.sv =====
// Shared interpolation unit: a + floor((b - a) * w / 2^16), three stages.
module tgu_lerp (
	input  logic               clk,
	input  logic               arst_n,
	input  tgu_pkg::lerp_req_t req,
	output tgu_pkg::lerp_rsp_t rsp
);

	logic                                                  vld_s1, vld_s2, vld_s3;
	logic signed [tgu_pkg::DIFF_W-1:0]                     diff_s1;
	tgu_pkg::val_t                                         a_s1, a_s2, res_s3;
	tgu_pkg::weight_t                                      w_s1;
	logic signed [tgu_pkg::DIFF_W+tgu_pkg::WEIGHT_W:0]     prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		diff_s1 <= {req.b[tgu_pkg::VAL_W-1], req.b} - {req.a[tgu_pkg::VAL_W-1], req.a};
		a_s1    <= req.a;
		w_s1    <= req.w;
		prod_s2 <= diff_s1 * $signed({1'b0, w_s1});
		a_s2    <= a_s1;
		// Dropping the low weight bits of a signed product rounds toward minus infinity.
		res_s3  <= a_s2 + prod_s2[tgu_pkg::WEIGHT_W +: tgu_pkg::VAL_W];
	end

	assign rsp.done   = vld_s3;
	assign rsp.result = res_s3;

endmodule

// ===== design/trilinear_grid_upsampler_top.sv =====
// Trilinear grid upsampler.
// The block keeps a coarse 3D grid of signed Q16.8 samples in a 4096-entry store and
// answers queries for points of a grid that is refined by an integer factor on every axis.
// Requests arrive on a valid/ready channel. A load request (command 0) writes one sample
// at its linear address and is finished in the cycle it is accepted; it produces no result.
// A query request (command 1) produces exactly one result on the response channel.
// A query runs through one sequencer: it clamps the fine coordinates and splits them into
// base index and weight with a shared reciprocal multiplier, one axis at a time, makes
// eleven reads through the single read port of the sample store and drains the last one,
// then runs seven interpolations on one shared three-stage unit and hands off the result.
// req_ready is low from the accepted query until the sequencer is back in idle, so a new
// query is only taken once the last one has been handed off. The store read port and the
// single interpolation unit set the query rate.
// The result sits in an output register. While the receiver stalls, the block still takes
// loads and the next query; a finished query waits in its last step until the register
// is free. Reset clears the sequencer, the output flag and the config registers (factor 2,
// sizes 16, no wrap) but not the sample store, whose entries are undefined until loaded.
// Configuration must be written over the APB port only while idle; nothing enforces it.
module trilinear_grid_upsampler_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [4:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic                                command,
	input  logic [tgu_pkg::ADDR_W-1:0]          coarse_address,
	input  logic signed [tgu_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [tgu_pkg::FINE_W-1:0]          fine_x,
	input  logic [tgu_pkg::FINE_W-1:0]          fine_y,
	input  logic [tgu_pkg::FINE_W-1:0]          fine_z,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic signed [tgu_pkg::SAMPLE_W-1:0] interpolated_value
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLAMP,
		S_DIV,
		S_READ,
		S_DRAIN,
		S_LERP_GO,
		S_LERP_WAIT,
		S_OUT
	} state_t;

	// Read slots: the base sample, the three backward neighbors, then corners one to seven.
	localparam logic [3:0] RD_BASE   = 4'd0;
	localparam logic [3:0] RD_PREV_X = 4'd1;
	localparam logic [3:0] RD_PREV_Y = 4'd2;
	localparam logic [3:0] RD_PREV_Z = 4'd3;
	localparam logic [3:0] RD_LAST   = 4'd10;
	localparam logic [1:0] AXIS_LAST = 2'd2;
	// Interpolation steps: four along x, two along y, one along z.
	localparam logic [2:0] LERP_X_LAST = 3'd3;
	localparam logic [2:0] LERP_Y_LAST = 3'd5;
	localparam logic [2:0] LERP_LAST   = 3'd6;

	// Configuration registers, as written.
	logic [tgu_pkg::FACTOR_W-1:0] factor_q;
	logic [tgu_pkg::SIZE_W-1:0]   size_x_q, size_y_q, size_z_q;
	logic                         wrap_q;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= tgu_pkg::FACTOR_W'(2);
			size_x_q <= tgu_pkg::SIZE_W'(tgu_pkg::MAX_AXIS);
			size_y_q <= tgu_pkg::SIZE_W'(tgu_pkg::MAX_AXIS);
			size_z_q <= tgu_pkg::SIZE_W'(tgu_pkg::MAX_AXIS);
			wrap_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				tgu_pkg::REG_FACTOR: factor_q <= pwdata[tgu_pkg::FACTOR_W-1:0];
				tgu_pkg::REG_SIZE_X: size_x_q <= pwdata[tgu_pkg::SIZE_W-1:0];
				tgu_pkg::REG_SIZE_Y: size_y_q <= pwdata[tgu_pkg::SIZE_W-1:0];
				tgu_pkg::REG_SIZE_Z: size_z_q <= pwdata[tgu_pkg::SIZE_W-1:0];
				tgu_pkg::REG_WRAP:   wrap_q   <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			tgu_pkg::REG_FACTOR: prdata = 32'(factor_q);
			tgu_pkg::REG_SIZE_X: prdata = 32'(size_x_q);
			tgu_pkg::REG_SIZE_Y: prdata = 32'(size_y_q);
			tgu_pkg::REG_SIZE_Z: prdata = 32'(size_z_q);
			tgu_pkg::REG_WRAP:   prdata = 32'(wrap_q);
			default:             prdata = '0;
		endcase
	end

	// Sequencer state and query context.
	state_t                                  state_q;
	logic [1:0]                              axis_q;
	logic [tgu_pkg::FINE_W-1:0]              fine_q [3];
	logic [tgu_pkg::SIZE_W-1:0]              n_q [3];
	logic [tgu_pkg::FACTOR_W-1:0]            f_q;
	logic [tgu_pkg::PLANE_W-1:0]             plane_q;
	logic [tgu_pkg::FINE_W-1:0]              fc_q;
	logic [tgu_pkg::IDX_W-1:0]               base_q [3];
	logic [tgu_pkg::IDX_W-1:0]               up_q [3];
	logic                                    miss_q [3];
	tgu_pkg::weight_t                        w_q [3];
	logic [3:0]                              issue_q;
	logic                                    cap_vld_s1;
	logic [3:0]                              cap_idx_s1;
	logic signed [tgu_pkg::SAMPLE_W-1:0]     v000_q;
	logic signed [tgu_pkg::SAMPLE_W:0]       d_q [3];
	tgu_pkg::val_t                           line_q [8];
	logic [2:0]                              lerp_cnt_q;
	logic signed [tgu_pkg::SAMPLE_W-1:0]     res_q;
	logic                                    rsp_valid_q;
	logic signed [tgu_pkg::SAMPLE_W-1:0]     rsp_value_q;

	logic req_acc, store_we;

	assign req_ready = (state_q == S_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign store_we  = req_acc && (command == tgu_pkg::CMD_LOAD);

	// Clamp step: the fine coordinate is limited to size times factor minus one.
	logic [tgu_pkg::FINE_W+1:0] span, limit, fine_ext;
	logic [tgu_pkg::FINE_W-1:0] fc_next;

	always_comb begin
		span     = {4'd0, n_q[axis_q]} * {5'd0, f_q};
		limit    = span - 9'd1;
		fine_ext = {2'd0, fine_q[axis_q]};
		fc_next  = (fine_ext > limit) ? limit[tgu_pkg::FINE_W-1:0] : fine_q[axis_q];
	end

	// Divide step: one reciprocal product holds the base index and the Q0.16 weight.
	logic [tgu_pkg::PROD_W-1:0]  div_prod;
	logic [tgu_pkg::IDX_W-1:0]   base_next;
	tgu_pkg::weight_t            w_next;
	logic [tgu_pkg::IDX_W:0]     up_full;
	logic                        up_hit;

	always_comb begin
		div_prod  = tgu_pkg::PROD_W'(fc_q) * tgu_pkg::PROD_W'(tgu_pkg::recip(f_q));
		base_next = div_prod[tgu_pkg::RECIP_SHIFT +: tgu_pkg::IDX_W];
		w_next    = div_prod[tgu_pkg::RECIP_SHIFT-tgu_pkg::WEIGHT_W +: tgu_pkg::WEIGHT_W];
		up_full   = {1'b0, base_next} + 5'd1;
		up_hit    = (up_full == n_q[axis_q]);
	end

	// Store address for the current read slot.
	logic [tgu_pkg::IDX_W-1:0]   rx, ry, rz;
	logic [2:0]                  rd_corner;
	logic [tgu_pkg::ADDR_W:0]    addr_x, addr_sum;
	logic [tgu_pkg::PLANE_W-1:0] addr_y;
	logic [tgu_pkg::ADDR_W-1:0]  raddr;

	always_comb begin
		rx        = base_q[0];
		ry        = base_q[1];
		rz        = base_q[2];
		rd_corner = 3'(issue_q - RD_PREV_Z);
		unique case (issue_q)
			RD_BASE: begin
			end
			RD_PREV_X: rx = base_q[0] - 4'd1;
			RD_PREV_Y: ry = base_q[1] - 4'd1;
			RD_PREV_Z: rz = base_q[2] - 4'd1;
			default: begin
				rx = rd_corner[2] ? up_q[0] : base_q[0];
				ry = rd_corner[1] ? up_q[1] : base_q[1];
				rz = rd_corner[0] ? up_q[2] : base_q[2];
			end
		endcase
		addr_x   = {9'd0, rx} * {4'd0, plane_q};
		addr_y   = {5'd0, ry} * {4'd0, n_q[2]};
		addr_sum = addr_x + 13'(addr_y) + 13'(rz);
		raddr    = addr_sum[tgu_pkg::ADDR_W-1:0];
	end

	logic [tgu_pkg::SAMPLE_W-1:0] rdata;

	tgu_store u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (coarse_address),
		.wdata (sample_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Captured read data: backward differences and corners, with edge extrapolation.
	tgu_pkg::val_t                   rd_val, ext_val, cap_val;
	logic signed [tgu_pkg::SAMPLE_W:0] diff_now;
	logic [2:0]                      cap_corner;
	logic [2:0]                      cap_pos;
	logic                            cap_any;
	logic [1:0]                      cap_axis;

	always_comb begin
		rd_val     = {{(tgu_pkg::VAL_W-tgu_pkg::SAMPLE_W){rdata[tgu_pkg::SAMPLE_W-1]}}, rdata};
		diff_now   = {v000_q[tgu_pkg::SAMPLE_W-1], v000_q}
		           - {rdata[tgu_pkg::SAMPLE_W-1], rdata};
		cap_axis   = 2'(cap_idx_s1 - RD_PREV_X);
		cap_corner = 3'(cap_idx_s1 - RD_PREV_Z);
		cap_pos    = {cap_corner[0], cap_corner[1], cap_corner[2]};
		cap_any    = (cap_corner[2] && miss_q[0]) || (cap_corner[1] && miss_q[1])
		          || (cap_corner[0] && miss_q[2]);
		ext_val    = {{(tgu_pkg::VAL_W-tgu_pkg::SAMPLE_W){v000_q[tgu_pkg::SAMPLE_W-1]}}, v000_q};
		for (int a = 0; a < 3; a++) begin
			if (cap_corner[2-a] && miss_q[a]) begin
				// Twice the difference, sign-extended to the wide value.
				ext_val = ext_val + tgu_pkg::val_t'($signed({d_q[a], 1'b0}));
			end
		end
		cap_val = cap_any ? ext_val : rd_val;
	end

	// Shared interpolation unit. Operands always come from the two head entries of the line.
	tgu_pkg::lerp_req_t lerp_req;
	tgu_pkg::lerp_rsp_t lerp_rsp;

	always_comb begin
		lerp_req.start = (state_q == S_LERP_GO);
		lerp_req.a     = line_q[0];
		lerp_req.b     = line_q[1];
		if (lerp_cnt_q <= LERP_X_LAST) begin
			lerp_req.w = w_q[0];
		end else if (lerp_cnt_q <= LERP_Y_LAST) begin
			lerp_req.w = w_q[1];
		end else begin
			lerp_req.w = w_q[2];
		end
	end

	tgu_lerp u_lerp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lerp_req),
		.rsp    (lerp_rsp)
	);

	// Control state of the sequencer and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			issue_q     <= '0;
			lerp_cnt_q  <= '0;
			cap_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			cap_vld_s1 <= (state_q == S_READ);
			// A finished query refills the output register as soon as it is free.
			if (state_q == S_OUT && (!rsp_valid_q || rsp_ready)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc && command == tgu_pkg::CMD_QUERY) begin
						axis_q  <= '0;
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: state_q <= S_DIV;
				S_DIV: begin
					if (axis_q == AXIS_LAST) begin
						issue_q <= RD_BASE;
						state_q <= S_READ;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= S_CLAMP;
					end
				end
				S_READ: begin
					if (issue_q == RD_LAST) begin
						state_q <= S_DRAIN;
					end else begin
						issue_q <= issue_q + 4'd1;
					end
				end
				S_DRAIN: begin
					lerp_cnt_q <= '0;
					state_q    <= S_LERP_GO;
				end
				S_LERP_GO: state_q <= S_LERP_WAIT;
				S_LERP_WAIT: begin
					if (lerp_rsp.done) begin
						lerp_cnt_q <= lerp_cnt_q + 3'd1;
						state_q    <= (lerp_cnt_q == LERP_LAST) ? S_OUT : S_LERP_GO;
					end
				end
				S_OUT: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Query context and datapath registers; none of them needs a reset value.
	always_ff @(posedge clk) begin
		if (req_acc && command == tgu_pkg::CMD_QUERY) begin
			fine_q[0] <= fine_x;
			fine_q[1] <= fine_y;
			fine_q[2] <= fine_z;
			n_q[0]    <= tgu_pkg::clamp_size(size_x_q);
			n_q[1]    <= tgu_pkg::clamp_size(size_y_q);
			n_q[2]    <= tgu_pkg::clamp_size(size_z_q);
			f_q       <= tgu_pkg::clamp_factor(factor_q);
			plane_q   <= {4'd0, tgu_pkg::clamp_size(size_y_q)}
			           * {4'd0, tgu_pkg::clamp_size(size_z_q)};
		end
		if (state_q == S_CLAMP) begin
			fc_q <= fc_next;
		end
		if (state_q == S_DIV) begin
			base_q[axis_q] <= base_next;
			w_q[axis_q]    <= w_next;
			// At the upper edge the neighbor either wraps to index zero or is extrapolated.
			miss_q[axis_q] <= up_hit && !wrap_q;
			up_q[axis_q]   <= up_hit ? '0 : up_full[tgu_pkg::IDX_W-1:0];
		end
		cap_idx_s1 <= issue_q;
		if (cap_vld_s1) begin
			if (cap_idx_s1 == RD_BASE) begin
				v000_q    <= rdata;
				line_q[0] <= rd_val;
			end else if (cap_idx_s1 <= RD_PREV_Z) begin
				// An axis with no lower neighbor contributes no difference.
				d_q[cap_axis] <= (base_q[cap_axis] != '0) ? diff_now : '0;
			end else begin
				line_q[cap_pos] <= cap_val;
			end
		end
		if (state_q == S_LERP_WAIT && lerp_rsp.done) begin
			// The line drops its two consumed heads and the new value joins its tail.
			for (int i = 0; i < 6; i++) begin
				line_q[i] <= (3'(i) == 3'(LERP_LAST - lerp_cnt_q)) ? lerp_rsp.result
				                                                    : line_q[i+2];
			end
			if (lerp_cnt_q == '0) begin
				line_q[LERP_LAST] <= lerp_rsp.result;
			end
			res_q <= tgu_pkg::saturate(lerp_rsp.result);
		end
		if (state_q == S_OUT && (!rsp_valid_q || rsp_ready)) begin
			rsp_value_q <= res_q;
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign interpolated_value = rsp_value_q;

	// Store read data is only captured while a query is fetching samples.
	a_cap_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		cap_vld_s1 |-> (state_q == S_READ || state_q == S_DRAIN))
		else $error("store data captured outside the read phase");

	// The interpolation unit only answers a step that the sequencer is waiting for.
	a_lerp_done: assert property (@(posedge clk) disable iff (!arst_n)
		lerp_rsp.done |-> state_q == S_LERP_WAIT)
		else $error("interpolation result arrived while not waiting");

	// Every base index lies inside its axis once the reads begin.
	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |-> ({1'b0, base_q[0]} < n_q[0] && {1'b0, base_q[1]} < n_q[1]
		                       && {1'b0, base_q[2]} < n_q[2]))
		else $error("base index beyond axis size");

	// A finished query that finds the output register free is handed off at once.
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!rsp_valid_q || rsp_ready)) |=> (rsp_valid_q && state_q == S_IDLE))
		else $error("finished query not handed to the output register");

	// A load never starts the sequencer.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		store_we |=> state_q == S_IDLE)
		else $error("load request left the idle state");

endmodule

// ===== test/tb_trilinear_grid_upsampler_top.sv =====
module tb_trilinear_grid_upsampler_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One request as the driver presents it. The fields that a command does not use
	// still carry random values so that the block is seen to ignore them.
	typedef struct packed {
		logic                                cmd;
		logic [tgu_pkg::ADDR_W-1:0]          addr;
		logic signed [tgu_pkg::SAMPLE_W-1:0] value;
		logic [tgu_pkg::FINE_W-1:0]          fx;
		logic [tgu_pkg::FINE_W-1:0]          fy;
		logic [tgu_pkg::FINE_W-1:0]          fz;
	} grid_request_t;

	logic                                clk;
	logic                                arst_n         = 1'b0;
	logic                                psel           = 1'b0;
	logic                                penable        = 1'b0;
	logic                                pwrite         = 1'b0;
	logic [4:0]                          paddr          = '0;
	logic [31:0]                         pwdata         = '0;
	logic [31:0]                         prdata;
	logic                                pready;
	logic                                req_valid      = 1'b0;
	logic                                req_ready;
	logic                                command        = tgu_pkg::CMD_LOAD;
	logic [tgu_pkg::ADDR_W-1:0]          coarse_address = '0;
	logic signed [tgu_pkg::SAMPLE_W-1:0] sample_value   = '0;
	logic [tgu_pkg::FINE_W-1:0]          fine_x         = '0;
	logic [tgu_pkg::FINE_W-1:0]          fine_y         = '0;
	logic [tgu_pkg::FINE_W-1:0]          fine_z         = '0;
	logic                                rsp_valid;
	logic                                rsp_ready      = 1'b0;
	logic signed [tgu_pkg::SAMPLE_W-1:0] interpolated_value;

	// Requests waiting for the driver, and the results the block still owes us.
	grid_request_t                       pending_requests[$];
	logic signed [tgu_pkg::SAMPLE_W-1:0] predicted_results[$];

	// Our own copy of the coarse grid. The known bits are set as soon as a load is
	// queued, so query generation can tell which entries are safe to read.
	logic signed [tgu_pkg::SAMPLE_W-1:0] sample_mem [tgu_pkg::STORE_DEPTH];
	bit                                  sample_known [tgu_pkg::STORE_DEPTH];
	logic [tgu_pkg::ADDR_W-1:0]          unseen_addrs[$];

	// Register shadow, updated after each configuration write completes.
	logic [tgu_pkg::FACTOR_W-1:0] cfg_factor = 4'd2;
	logic [tgu_pkg::SIZE_W-1:0]   cfg_size [3] = '{5'd16, 5'd16, 5'd16};
	logic                         cfg_wrap = 1'b0;

	logic request_taken = 1'b0;
	bit   steady        = 1'b0;
	int   rsp_stall_left = 0;
	int   queued_items  = 0;
	int   error_count   = 0;

	trilinear_grid_upsampler_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.psel               (psel),
		.penable            (penable),
		.pwrite             (pwrite),
		.paddr              (paddr),
		.pwdata             (pwdata),
		.prdata             (prdata),
		.pready             (pready),
		.req_valid          (req_valid),
		.req_ready          (req_ready),
		.command            (command),
		.coarse_address     (coarse_address),
		.sample_value       (sample_value),
		.fine_x             (fine_x),
		.fine_y             (fine_y),
		.fine_z             (fine_z),
		.rsp_valid          (rsp_valid),
		.rsp_ready          (rsp_ready),
		.interpolated_value (interpolated_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Out-of-range register values fold back the same way for factor and sizes:
	// zero behaves as one and anything above the maximum behaves as the maximum.
	function automatic int clamp_to(input int v, input int hi);
		if (v == 0) return 1;
		return (v > hi) ? hi : v;
	endfunction

	// Reads one coarse sample by grid position. Entries that were never loaded are
	// collected so the query generator can load them before the query goes out.
	function automatic longint read_sample(input int x, input int y, input int z,
	                                       input int ny, input int nz);
		logic [tgu_pkg::ADDR_W-1:0] idx;
		idx = tgu_pkg::ADDR_W'(z + nz * (y + ny * x));
		if (!sample_known[idx]) unseen_addrs.push_back(idx);
		return longint'(sample_mem[idx]);
	endfunction

	// One linear step; the arithmetic shift floors toward minus infinity.
	function automatic longint blend(input longint a, input longint b, input longint w);
		return a + (((b - a) * w) >>> tgu_pkg::WEIGHT_W);
	endfunction

	// Expected value for one fine-grid point under the current register settings.
	function automatic logic signed [tgu_pkg::SAMPLE_W-1:0] interpolate_point(
		input logic [tgu_pkg::FINE_W-1:0] fx,
		input logic [tgu_pkg::FINE_W-1:0] fy,
		input logic [tgu_pkg::FINE_W-1:0] fz
	);
		int     f, a, k;
		int     n[3], pos[3], base[3], upper[3], pick[3];
		bit     missing[3];
		bit     extrap;
		longint wt[3], slope[3], corner[8];
		longint v000, c00, c10, c01, c11, c0, c1, c;
		f = clamp_to(cfg_factor, tgu_pkg::MAX_FACTOR);
		pos[0] = fx;
		pos[1] = fy;
		pos[2] = fz;
		for (a = 0; a < 3; a++) begin
			n[a] = clamp_to(cfg_size[a], tgu_pkg::MAX_AXIS);
			// Points past the fine grid stick to its last point.
			if (pos[a] > n[a] * f - 1) pos[a] = n[a] * f - 1;
			base[a] = pos[a] / f;
			wt[a] = (longint'(pos[a] % f) << tgu_pkg::WEIGHT_W) / f;
			upper[a] = base[a] + 1;
			missing[a] = 1'b0;
			if (upper[a] == n[a]) begin
				if (cfg_wrap) upper[a] = 0;
				else missing[a] = 1'b1;
			end
		end
		v000 = read_sample(base[0], base[1], base[2], n[1], n[2]);
		// Backward differences feed the edge extrapolation; a base at index zero has
		// no previous sample, so its difference is zero.
		slope[0] = (base[0] > 0) ?
			v000 - read_sample(base[0] - 1, base[1], base[2], n[1], n[2]) : 0;
		slope[1] = (base[1] > 0) ?
			v000 - read_sample(base[0], base[1] - 1, base[2], n[1], n[2]) : 0;
		slope[2] = (base[2] > 0) ?
			v000 - read_sample(base[0], base[1], base[2] - 1, n[1], n[2]) : 0;
		// Corner bit 2 picks the upper x neighbor, bit 1 upper y, bit 0 upper z.
		for (k = 0; k < 8; k++) begin
			extrap = 1'b0;
			corner[k] = v000;
			for (a = 0; a < 3; a++) begin
				pick[a] = base[a];
				if (((k >> (2 - a)) & 1) != 0) begin
					if (missing[a]) begin
						extrap = 1'b1;
						corner[k] += 2 * slope[a];
					end else begin
						pick[a] = upper[a];
					end
				end
			end
			if (!extrap) corner[k] = read_sample(pick[0], pick[1], pick[2], n[1], n[2]);
		end
		c00 = blend(corner[0], corner[4], wt[0]);
		c10 = blend(corner[2], corner[6], wt[0]);
		c01 = blend(corner[1], corner[5], wt[0]);
		c11 = blend(corner[3], corner[7], wt[0]);
		c0  = blend(c00, c10, wt[1]);
		c1  = blend(c01, c11, wt[1]);
		c   = blend(c0, c1, wt[2]);
		// Only the final value is saturated; every intermediate is kept wide.
		if (c > longint'(8388607)) c = 8388607;
		if (c < longint'(-8388608)) c = -8388608;
		return tgu_pkg::SAMPLE_W'(c);
	endfunction

	// Sample values lean on the two extremes and on small numbers near zero.
	function automatic logic signed [tgu_pkg::SAMPLE_W-1:0] random_sample();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10) return {1'b0, {(tgu_pkg::SAMPLE_W-1){1'b1}}};
		if (roll < 20) return {1'b1, {(tgu_pkg::SAMPLE_W-1){1'b0}}};
		if (roll < 50) return tgu_pkg::SAMPLE_W'($urandom_range(2047)) - tgu_pkg::SAMPLE_W'(1024);
		return tgu_pkg::SAMPLE_W'($urandom);
	endfunction

	function automatic void queue_load(input logic [tgu_pkg::ADDR_W-1:0] addr,
	                                   input logic signed [tgu_pkg::SAMPLE_W-1:0] value);
		grid_request_t item;
		item.cmd   = tgu_pkg::CMD_LOAD;
		item.addr  = addr;
		item.value = value;
		item.fx    = tgu_pkg::FINE_W'($urandom);
		item.fy    = tgu_pkg::FINE_W'($urandom);
		item.fz    = tgu_pkg::FINE_W'($urandom);
		sample_known[addr] = 1'b1;
		pending_requests.push_back(item);
		queued_items++;
	endfunction

	// A dry run of the interpolation lists the entries the query will touch; any
	// of them not yet loaded gets a load request ahead of the query.
	function automatic void queue_query(input logic [tgu_pkg::FINE_W-1:0] fx,
	                                    input logic [tgu_pkg::FINE_W-1:0] fy,
	                                    input logic [tgu_pkg::FINE_W-1:0] fz);
		grid_request_t item;
		unseen_addrs.delete();
		void'(interpolate_point(fx, fy, fz));
		foreach (unseen_addrs[i]) begin
			if (!sample_known[unseen_addrs[i]]) queue_load(unseen_addrs[i], random_sample());
		end
		item.cmd   = tgu_pkg::CMD_QUERY;
		item.addr  = tgu_pkg::ADDR_W'($urandom);
		item.value = tgu_pkg::SAMPLE_W'($urandom);
		item.fx    = fx;
		item.fy    = fy;
		item.fz    = fz;
		pending_requests.push_back(item);
		queued_items++;
	endfunction

	// Fine coordinates: mostly inside the fine grid, often near its top edge where
	// wrap or extrapolation kicks in, and sometimes anywhere in the 7-bit range.
	function automatic logic [tgu_pkg::FINE_W-1:0] pick_fine(input int span);
		int roll;
		roll = $urandom_range(99);
		if (roll < 70) return tgu_pkg::FINE_W'($urandom_range(span - 1));
		if (roll < 85) begin
			return tgu_pkg::FINE_W'($urandom_range(span - 1, (span > 8) ? span - 8 : 0));
		end
		return tgu_pkg::FINE_W'($urandom_range(127));
	endfunction

	function automatic void queue_random_batch(input int count);
		int stop, roll, f, grid_points;
		int span[3];
		stop = queued_items + count;
		f = clamp_to(cfg_factor, tgu_pkg::MAX_FACTOR);
		grid_points = 1;
		foreach (span[a]) begin
			span[a] = clamp_to(cfg_size[a], tgu_pkg::MAX_AXIS) * f;
			grid_points *= clamp_to(cfg_size[a], tgu_pkg::MAX_AXIS);
		end
		while (queued_items < stop) begin
			roll = $urandom_range(99);
			if (roll < 60) begin
				queue_query(pick_fine(span[0]), pick_fine(span[1]), pick_fine(span[2]));
			end else if (roll < 90) begin
				// Rewrite a sample inside the current grid so later queries see new data.
				queue_load(tgu_pkg::ADDR_W'($urandom_range(grid_points - 1)), random_sample());
			end else begin
				queue_load(tgu_pkg::ADDR_W'($urandom), random_sample());
			end
		end
	endfunction

	// Reads a register back over the configuration port and compares it.
	task automatic check_reg(input logic [2:0] idx, input logic [31:0] expected);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b0;
		penable = 1'b0;
		paddr   = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== expected) begin
			$display("%0t: register %0d read back %0h, expected %0h",
			         $time, idx, prdata, expected);
			error_count++;
		end
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] kept;
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		kept    = '0;
		case (idx)
			tgu_pkg::REG_FACTOR: begin
				cfg_factor = value[tgu_pkg::FACTOR_W-1:0];
				kept = 32'(cfg_factor);
			end
			tgu_pkg::REG_SIZE_X: begin
				cfg_size[0] = value[tgu_pkg::SIZE_W-1:0];
				kept = 32'(cfg_size[0]);
			end
			tgu_pkg::REG_SIZE_Y: begin
				cfg_size[1] = value[tgu_pkg::SIZE_W-1:0];
				kept = 32'(cfg_size[1]);
			end
			tgu_pkg::REG_SIZE_Z: begin
				cfg_size[2] = value[tgu_pkg::SIZE_W-1:0];
				kept = 32'(cfg_size[2]);
			end
			tgu_pkg::REG_WRAP: begin
				cfg_wrap = value[0];
				kept = 32'(cfg_wrap);
			end
			default: begin
			end
		endcase
		check_reg(idx, kept);
	endtask

	// Idle means: nothing queued, nothing offered and no result outstanding. Load
	// requests give no result, so the task keeps waiting afterwards to cover the pipeline
	// depth before registers are touched.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_requests.size() != 0 || req_valid || predicted_results.size() != 0);
		repeat (60) @(posedge clk);
	endtask

	// One configuration phase: program every register while idle, then two random
	// batches with a full drain between them so the sender also pauses mid-phase.
	task automatic run_phase(input int factor, input int nx, input int ny, input int nz,
	                         input int wrap, input int count, input bit calm,
	                         input int stall_cycles);
		wait_drained();
		write_reg(tgu_pkg::REG_FACTOR, factor);
		write_reg(tgu_pkg::REG_SIZE_X, nx);
		write_reg(tgu_pkg::REG_SIZE_Y, ny);
		write_reg(tgu_pkg::REG_SIZE_Z, nz);
		write_reg(tgu_pkg::REG_WRAP, wrap);
		@(posedge clk);
		steady = calm;
		rsp_stall_left = stall_cycles;
		queue_random_batch(count / 2);
		wait_drained();
		queue_random_batch(count - count / 2);
	endtask

	// Request driver. A new request may only replace the current one once it was
	// taken; each branch gives req_valid a single update per falling edge. Unless a
	// steady stretch runs, a pending request is held back with a 16 percent chance.
	always @(negedge clk) begin
		grid_request_t item;
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || request_taken) begin
			if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 16)) begin
				item = pending_requests.pop_front();
				command        <= item.cmd;
				coarse_address <= item.addr;
				sample_value   <= item.value;
				fine_x         <= item.fx;
				fine_y         <= item.fy;
				fine_z         <= item.fz;
				req_valid      <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Result receiver. A long hold-off is counted down here while the driver keeps
	// offering requests, which backs the block up until it stops taking requests.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (rsp_stall_left > 0) begin
			rsp_stall_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= steady || ($urandom_range(99) >= 16);
		end
	end

	// Monitor. Accepted loads update the grid copy; accepted queries get their
	// expected value computed right away and queued in order. Each result is checked
	// against the oldest expectation.
	always @(posedge clk) begin
		logic signed [tgu_pkg::SAMPLE_W-1:0] want;
		request_taken <= req_valid && req_ready;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				if (command == tgu_pkg::CMD_LOAD) begin
					sample_mem[coarse_address] = sample_value;
				end else begin
					predicted_results.push_back(interpolate_point(fine_x, fine_y, fine_z));
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (predicted_results.size() == 0) begin
					$display("%0t: result %0d arrived with no query outstanding",
					         $time, interpolated_value);
					error_count++;
				end else begin
					want = predicted_results.pop_front();
					if (interpolated_value !== want) begin
						$display("%0t: interpolated_value expected %0d, got %0d",
						         $time, want, interpolated_value);
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Registers must come out of reset at their documented defaults.
		check_reg(tgu_pkg::REG_FACTOR, 2);
		check_reg(tgu_pkg::REG_SIZE_X, 16);
		check_reg(tgu_pkg::REG_SIZE_Y, 16);
		check_reg(tgu_pkg::REG_SIZE_Z, 16);
		check_reg(tgu_pkg::REG_WRAP, 0);

		// Directed part on a 2x2x2 grid with the largest factor, so every corner is
		// loaded by hand and the top cell is reached quickly. The top sample is the
		// positive extreme and the origin the negative one, which drives the
		// extrapolated corners far past the output range.
		write_reg(tgu_pkg::REG_FACTOR, 8);
		write_reg(tgu_pkg::REG_SIZE_X, 2);
		write_reg(tgu_pkg::REG_SIZE_Y, 2);
		write_reg(tgu_pkg::REG_SIZE_Z, 2);
		write_reg(tgu_pkg::REG_WRAP, 0);
		@(posedge clk);
		queue_load(tgu_pkg::ADDR_W'(tgu_pkg::STORE_DEPTH - 1),
		           {1'b1, {(tgu_pkg::SAMPLE_W-1){1'b0}}});
		queue_load(0, {1'b1, {(tgu_pkg::SAMPLE_W-1){1'b0}}});
		queue_load(1, 1000);
		queue_load(2, -1000);
		queue_load(3, 65536);
		queue_load(4, random_sample());
		queue_load(5, random_sample());
		queue_load(6, -7);
		queue_load(7, {1'b0, {(tgu_pkg::SAMPLE_W-1){1'b1}}});
		queue_query(0, 0, 0);        // exact base sample, all weights zero
		queue_query(4, 4, 4);        // cell center, half weights
		queue_query(15, 15, 15);     // all three upper corners extrapolated
		queue_query(127, 127, 127);  // coordinates past the fine grid
		queue_query(0, 0, 15);       // extrapolation along the fast axis only
		queue_query(7, 0, 127);
		queue_query(8, 3, 0);
		wait_drained();
		write_reg(tgu_pkg::REG_WRAP, 1);
		@(posedge clk);
		queue_query(15, 15, 15);     // upper neighbors wrap to index zero
		queue_query(12, 5, 9);
		queue_query(127, 0, 64);

		// Random phases, including the register extremes and out-of-range values.
		// The second full-size phase opens with a long receiver stall; the third phase runs
		// with no idling on either side.
		run_phase(2, 16, 16, 16, 0, 170, 1'b0, 0);
		run_phase(8, 16, 16, 16, 1, 170, 1'b0, 400);
		run_phase(1, 1, 1, 1, 0, 170, 1'b1, 0);
		run_phase(3, 5, 2, 7, 0, 170, 1'b0, 0);
		run_phase(0, 0, 17, 31, 1, 170, 1'b0, 0);
		run_phase(15, 1, 16, 3, 0, 170, 1'b0, 0);
		run_phase(5, 4, 4, 4, 1, 170, 1'b0, 0);
		run_phase(7, 16, 1, 9, 0, 170, 1'b0, 0);
		run_phase($urandom_range(15), $urandom_range(31), $urandom_range(31),
		          $urandom_range(31), $urandom_range(1), 170, 1'b0, 0);
		run_phase($urandom_range(15), $urandom_range(31), $urandom_range(31),
		          $urandom_range(31), $urandom_range(1), 170, 1'b0, 0);

		// Everything queued has been taken and answered once this returns; the
		// trailing cycles give a stray extra result time to show up.
		wait_drained();
		if (error_count == 0) begin
			$display("trilinear_grid_upsampler_top test passed");
		end else begin
			$display("trilinear_grid_upsampler_top test failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#10_000_000;
		$display("trilinear_grid_upsampler_top test failed");
		$finish;
	end

endmodule
